@@ rtl/core/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`endif

@@ rtl/core/ldbr_pkg.sv @@
// ----------------------------------------------------------------------------
// ldbr_pkg
// shared types and constants of the lcd dirty byte refresh block
// ----------------------------------------------------------------------------
package ldbr_pkg;

  localparam int COLUMNS_PER_CHIP_DEF = 64;
  localparam int PAGES_DEF            = 8;
  localparam int QUEUE_DEPTH          = 4;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_PAGE   = 2'd1;
  localparam logic [1:0] KIND_COLUMN = 2'd2;

  // one classified byte position, as handed from front to back
  typedef struct packed {
    logic       hdr;
    logic       col_cmd;
    logic       wr;
    logic       chip;
    logic [7:0] page;
    logic [7:0] col;
    logic [7:0] data;
  } desc_t;

endpackage

@@ rtl/core/ldbr_front.sv @@
// ----------------------------------------------------------------------------
// ldbr_front
// scan position tracking and byte classification
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ldbr_front import ldbr_pkg::*; #(
  parameter int COLUMNS_PER_CHIP = COLUMNS_PER_CHIP_DEF,
  parameter int PAGES            = PAGES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] new_byte,
  input  logic [7:0] old_byte,
  output logic       q_push,
  input  logic       q_full,
  output desc_t      q_desc
);

  localparam int COL_W  = (COLUMNS_PER_CHIP > 1) ? $clog2(COLUMNS_PER_CHIP) : 1;
  localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;

  logic [COL_W-1:0]  col;
  logic              chip;
  logic [PAGE_W-1:0] page;
  logic              stale;

  logic acc;
  logic at_col0;
  logic frame_start;
  logic changed;
  logic stale_eff;
  logic col_wrap;
  logic page_wrap;

  assign full        = q_full;
  assign acc         = push && !q_full;
  assign at_col0     = (col == '0);
  assign frame_start = at_col0 && !chip && (page == '0);
  assign changed     = (new_byte != old_byte);
  assign stale_eff   = stale || frame_start;
  assign col_wrap    = (col == COL_W'(COLUMNS_PER_CHIP - 1));
  assign page_wrap   = (page == PAGE_W'(PAGES - 1));

  assign q_push          = acc && (at_col0 || changed);
  assign q_desc.hdr      = at_col0;
  assign q_desc.col_cmd  = changed && stale_eff;
  assign q_desc.wr       = changed;
  assign q_desc.chip     = chip;
  assign q_desc.page     = 8'(page);
  assign q_desc.col      = 8'(col);
  assign q_desc.data     = new_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      chip  <= 1'b0;
      page  <= '0;
      stale <= 1'b1;
    end else if (acc) begin
      stale <= !changed;
      if (col_wrap) begin
        col  <= '0;
        chip <= !chip;
        if (chip) begin
          page <= page_wrap ? '0 : page + PAGE_W'(1);
        end
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // a frame always opens with a page header and a fresh column address
  `ASSERT_IMPLY(a_frame_start_hdr, clk, rst, acc && frame_start,
                q_push && q_desc.hdr && (q_desc.col_cmd || !changed))
  `ASSERT_NEVER(a_page_range, clk, rst, page > PAGE_W'(PAGES - 1))

endmodule

@@ rtl/core/ldbr_queue.sv @@
// ----------------------------------------------------------------------------
// ldbr_queue
// short register queue between classification and command emission
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ldbr_queue import ldbr_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  desc_t wr_data,
  output logic  full,
  input  logic  rd,
  output desc_t rd_data,
  output logic  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  desc_t             mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_wr;
  logic              do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk, rst, wr && full)
  `ASSERT_NEVER(a_count_range, clk, rst, count > CNT_W'(DEPTH))

endmodule

@@ rtl/core/ldbr_back.sv @@
// ----------------------------------------------------------------------------
// ldbr_back
// expands each classified position into display commands and data writes
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ldbr_back import ldbr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  desc_t      q_desc,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] kind,
  output logic [7:0] value,
  output logic       chip,
  output logic       last
);

  localparam logic [1:0] PH_PAGE = 2'd0;
  localparam logic [1:0] PH_COL0 = 2'd1;
  localparam logic [1:0] PH_COL  = 2'd2;
  localparam logic [1:0] PH_DATA = 2'd3;

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [1:0] cur;
  logic [1:0] start_ph;
  logic       started;
  logic       emit;
  logic       emit_last;
  logic [1:0] emit_kind;
  logic [7:0] emit_value;

  logic       ovalid;
  logic [1:0] okind;
  logic [7:0] ovalue;
  logic       ochip;
  logic       olast;

  always_comb begin
    if (q_desc.hdr) begin
      start_ph = PH_PAGE;
    end else if (q_desc.col_cmd) begin
      start_ph = PH_COL;
    end else begin
      start_ph = PH_DATA;
    end
  end

  assign cur  = started ? phase : start_ph;
  assign emit = !q_empty && (!ovalid || pop);

  always_comb begin
    phase_next = PH_DATA;
    emit_last  = 1'b1;
    emit_kind  = KIND_DATA;
    emit_value = q_desc.data;
    unique case (cur)
      PH_PAGE: begin
        emit_kind  = KIND_PAGE;
        emit_value = q_desc.page;
        emit_last  = 1'b0;
        phase_next = PH_COL0;
      end
      PH_COL0: begin
        emit_kind  = KIND_COLUMN;
        emit_value = 8'd0;
        emit_last  = !q_desc.col_cmd && !q_desc.wr;
        phase_next = q_desc.col_cmd ? PH_COL : PH_DATA;
      end
      PH_COL: begin
        emit_kind  = KIND_COLUMN;
        emit_value = q_desc.col;
        emit_last  = 1'b0;
        phase_next = PH_DATA;
      end
      PH_DATA: begin
        emit_kind  = KIND_DATA;
        emit_value = q_desc.data;
        emit_last  = 1'b1;
        phase_next = PH_DATA;
      end
      default: begin
        emit_kind  = KIND_DATA;
        emit_value = q_desc.data;
        emit_last  = 1'b1;
        phase_next = PH_DATA;
      end
    endcase
  end

  assign q_pop = emit && emit_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      phase   <= PH_PAGE;
      ovalid  <= 1'b0;
    end else begin
      if (emit) begin
        started <= !emit_last;
        phase   <= phase_next;
        ovalid  <= 1'b1;
      end else if (pop) begin
        ovalid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      okind  <= emit_kind;
      ovalue <= emit_value;
      ochip  <= q_desc.chip;
      olast  <= emit_last;
    end
  end

  assign empty = !ovalid;
  assign kind  = okind;
  assign value = ovalue;
  assign chip  = ochip;
  assign last  = olast;

  // a descriptor in progress keeps its queue entry until its final transaction
  `ASSERT_IMPLY(a_head_held, clk, rst, started, !q_empty)
  `ASSERT_IMPLY(a_pop_on_last, clk, rst, q_pop, emit && emit_last)

endmodule

@@ rtl/core/lcd_dirty_byte_refresh.sv @@
// ----------------------------------------------------------------------------
// lcd_dirty_byte_refresh
// delta refresh command generator for a two-chip page-organised lcd
// ----------------------------------------------------------------------------
// Frame bytes enter as new/old pairs in scan order, one per cycle when full
// is low; every pair is taken while full is low, whether or not it produces
// output. A classifier tracks the scan position and address flag and posts
// each position that needs output into a four-entry queue. The emitter drains
// the queue at one command or data transaction per cycle unless pop holds
// the output, so a half start with a changed byte takes up to four
// transactions and an unchanged byte inside a half takes none; sustained
// throughput is bounded by the output rate of one transaction per cycle.
// last marks the final transaction of a byte. No clearing pass is needed after reset.

module lcd_dirty_byte_refresh import ldbr_pkg::*; #(
  parameter int COLUMNS_PER_CHIP = COLUMNS_PER_CHIP_DEF,
  parameter int PAGES            = PAGES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] new_byte,
  input  logic [7:0] old_byte,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] kind,
  output logic [7:0] value,
  output logic       chip,
  output logic       last
);

  desc_t wr_desc;
  desc_t rd_desc;
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;

  ldbr_front #(
    .COLUMNS_PER_CHIP (COLUMNS_PER_CHIP),
    .PAGES            (PAGES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .new_byte (new_byte),
    .old_byte (old_byte),
    .q_push   (q_push),
    .q_full   (q_full),
    .q_desc   (wr_desc)
  );

  ldbr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (wr_desc),
    .full    (q_full),
    .rd      (q_pop),
    .rd_data (rd_desc),
    .empty   (q_empty)
  );

  ldbr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_desc  (rd_desc),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .kind    (kind),
    .value   (value),
    .chip    (chip),
    .last    (last)
  );

endmodule

@@ test/ldbr_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ldbr_checker
// watches both queue ports of the lcd dirty byte refresh block, predicts the
// command stream from every accepted byte pair and compares each popped
// transaction field by field against the oldest predicted command
// ----------------------------------------------------------------------------
module ldbr_checker import ldbr_pkg::*; #(
  parameter int COLUMNS_PER_CHIP = COLUMNS_PER_CHIP_DEF,
  parameter int PAGES            = PAGES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] new_byte,
  input  logic [7:0] old_byte,
  input  logic       empty,
  input  logic       pop,
  input  logic [1:0] kind,
  input  logic [7:0] value,
  input  logic       chip,
  input  logic       last,
  output int         fault_count,
  output int         cmds_pending
);

  localparam int FRAME_BYTES = 2 * COLUMNS_PER_CHIP * PAGES;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       chip;
    logic       last;
  } lcd_cmd_t;

  lcd_cmd_t    cmd_expected[$];
  int unsigned frame_pos;
  logic        addr_stale;

  function automatic void add_cmd(logic [1:0] k, logic [7:0] v, logic side);
    lcd_cmd_t c;
    c.kind  = k;
    c.value = v;
    c.chip  = side;
    c.last  = 1'b0;
    cmd_expected.push_back(c);
  endfunction

  function automatic void plan_commands(logic [7:0] nb, logic [7:0] ob);
    int unsigned col;
    int unsigned page;
    logic        side;
    int          before_cnt;
    before_cnt = cmd_expected.size();
    col  = frame_pos % COLUMNS_PER_CHIP;
    side = ((frame_pos / COLUMNS_PER_CHIP) % 2) == 1;
    page = frame_pos / (2 * COLUMNS_PER_CHIP);
    if (frame_pos == 0) addr_stale = 1'b1;
    if (col == 0) begin
      add_cmd(KIND_PAGE, page[7:0], side);
      add_cmd(KIND_COLUMN, 8'd0, side);
    end
    if (nb != ob) begin
      if (addr_stale) add_cmd(KIND_COLUMN, col[7:0], side);
      add_cmd(KIND_DATA, nb, side);
      addr_stale = 1'b0;
    end else begin
      addr_stale = 1'b1;
    end
    if (cmd_expected.size() > before_cnt)
      cmd_expected[cmd_expected.size() - 1].last = 1'b1;
    frame_pos = (frame_pos + 1 >= FRAME_BYTES) ? 0 : frame_pos + 1;
  endfunction

  function automatic void check_cmd();
    lcd_cmd_t want;
    if (cmd_expected.size() == 0) begin
      fault_count++;
      if (fault_count <= 10)
        $display("unexpected transaction: kind %0d value %0d chip %0d last %0d",
                 kind, value, chip, last);
      return;
    end
    want = cmd_expected.pop_front();
    if (kind !== want.kind || value !== want.value || chip !== want.chip ||
        last !== want.last) begin
      fault_count++;
      if (fault_count <= 10)
        $display("mismatch: expected kind %0d value %0d chip %0d last %0d, %s%0d%s%0d%s%0d%s%0d",
                 want.kind, want.value, want.chip, want.last,
                 "got kind ", kind, " value ", value, " chip ", chip, " last ", last);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cmd_expected.delete();
      frame_pos   = 0;
      addr_stale  = 1'b1;
      fault_count = 0;
    end else begin
      if (pop && !empty) check_cmd();
      if (push && !full) plan_commands(new_byte, old_byte);
    end
    cmds_pending = cmd_expected.size();
  end

endmodule

@@ test/lcd_dirty_byte_refresh_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcd_dirty_byte_refresh_tb
// drives new/old frame byte pairs across the first pages of a frame, first a
// short directed sequence, then runs of mostly changed, mostly unchanged or
// mixed bytes, with random bursts of idle cycles on both ports; the checker
// reports every wrong, missing or extra command transaction
// ----------------------------------------------------------------------------
module lcd_dirty_byte_refresh_tb import ldbr_pkg::*; ();

  localparam int ITEM_TARGET  = 500;
  localparam int CALM_ITEMS   = 100;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] new_byte;
  logic [7:0] old_byte;
  logic       empty;
  logic       pop;
  logic [1:0] kind;
  logic [7:0] value;
  logic       chip;
  logic       last;
  int         fault_count;
  int         cmds_pending;
  int         sent;
  bit         calm;
  bit         push_gaps;
  int         quiet_cycles;

  lcd_dirty_byte_refresh i_dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .new_byte (new_byte),
    .old_byte (old_byte),
    .empty    (empty),
    .pop      (pop),
    .kind     (kind),
    .value    (value),
    .chip     (chip),
    .last     (last)
  );

  ldbr_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .new_byte     (new_byte),
    .old_byte     (old_byte),
    .empty        (empty),
    .pop          (pop),
    .kind         (kind),
    .value        (value),
    .chip         (chip),
    .last         (last),
    .fault_count  (fault_count),
    .cmds_pending (cmds_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic send_pair(input logic [7:0] nb, input logic [7:0] ob);
    if (!calm && push_gaps && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    push     <= 1'b1;
    new_byte <= nb;
    old_byte <= ob;
    do @(posedge clk); while (full);
    sent++;
  endtask

  // result side: stretches with and without stall bursts
  initial begin
    int stretch;
    bit stalls_on;
    pop <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stretch   = $urandom_range(4, 40);
      stalls_on = $urandom_range(0, 1);
      repeat (stretch) begin
        if (!calm && stalls_on && $urandom_range(0, 2) == 0) begin
          pop <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] nb;
    logic [7:0] ob;
    int         run_len;
    int         dirty_pct;
    rst       <= 1'b1;
    push      <= 1'b0;
    new_byte  <= 8'h00;
    old_byte  <= 8'h00;
    sent      = 0;
    calm      = 1'b0;
    push_gaps = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // frame start, changed byte at column 0 with stale address
    send_pair(8'hA5, 8'h5A);
    send_pair(8'h00, 8'hFF);
    send_pair(8'hFF, 8'h00);
    send_pair(8'h00, 8'h00);
    send_pair(8'hFF, 8'hFF);
    // changed after unchanged needs a new column address
    send_pair(8'h01, 8'h00);
    send_pair(8'h80, 8'h7F);
    send_pair(8'h55, 8'h55);
    send_pair(8'hAA, 8'h55);
    send_pair(8'h7F, 8'h80);
    send_pair(8'h12, 8'h12);
    send_pair(8'h34, 8'h34);
    send_pair(8'hFE, 8'hFF);
    send_pair(8'h00, 8'h01);
    send_pair(8'hC3, 8'h3C);
    send_pair(8'h99, 8'h99);
    send_pair(8'h0F, 8'hF0);
    send_pair(8'hF0, 8'h0F);
    send_pair(8'h66, 8'h66);
    send_pair(8'h01, 8'h80);

    while (sent < ITEM_TARGET) begin
      run_len   = $urandom_range(1, 12);
      push_gaps = $urandom_range(0, 2) != 0;
      case ($urandom_range(0, 2))
        0:       dirty_pct = 90;
        1:       dirty_pct = 10;
        default: dirty_pct = 50;
      endcase
      repeat (run_len) begin
        nb = 8'($urandom_range(0, 255));
        if ($urandom_range(1, 100) <= dirty_pct) ob = nb ^ 8'($urandom_range(1, 255));
        else ob = nb;
        if (sent >= ITEM_TARGET - CALM_ITEMS) calm = 1'b1;
        send_pair(nb, ob);
      end
    end
    push <= 1'b0;

    @(posedge clk);
    while (cmds_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
